// ----- design/mjd_pkg.sv -----
// Shared types and constants for the multicore job dispatcher.
`timescale 1ns / 1ps

package mjd_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int MAX_CORES   = 32;
  localparam int TICK_BITS   = 16;

  localparam int QW      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int SW      = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
  localparam int CORE_W  = 6;
  localparam int QCAP_W  = 5;
  localparam int STAT_W  = 24;
  localparam int CFG_AW  = 1;
  localparam int CFG_DW  = 6;

  localparam logic [STAT_W-1:0] STAT_MAX = {STAT_W{1'b1}};

  localparam logic [QCAP_W-1:0] QCAP_RESET  = 5'd16;
  localparam logic [CORE_W-1:0] CORES_RESET = 6'd32;

  localparam logic [CFG_AW-1:0] REG_QUEUE_CAPACITY = 1'b0;
  localparam logic [CFG_AW-1:0] REG_CORE_COUNT     = 1'b1;

  localparam logic [1:0] ARR_NONE   = 2'd0;
  localparam logic [1:0] ARR_QUEUED = 2'd1;
  localparam logic [1:0] ARR_FULL   = 2'd2;
  localparam logic [1:0] ARR_WIDE   = 2'd3;

  typedef struct packed {
    logic                 job_arrives;
    logic [CORE_W-1:0]    job_cores;
    logic [TICK_BITS-1:0] job_ticks;
  } job_in_t;

  typedef struct packed {
    logic [CORE_W-1:0]    cores;
    logic [TICK_BITS-1:0] ticks;
  } job_entry_t;

  typedef struct packed {
    logic [1:0]        arrival_status;
    logic              dispatched;
    logic [5:0]        completed_now;
    logic              idle_tick;
    logic [5:0]        free_cores;
    logic [4:0]        queue_fill;
    logic [STAT_W-1:0] tasks_generated;
    logic [STAT_W-1:0] total_completed;
    logic [STAT_W-1:0] total_queue_full;
    logic [STAT_W-1:0] total_too_wide;
    logic [STAT_W-1:0] total_idle;
  } result_t;

endpackage

// ----- design/multicore_job_dispatcher_top.sv -----
// Each request passes the states ARR, HEAD and DISP, a walk over the run slots (SCAN) and
// DONE; a new request is taken only in IDLE, once the result of the last one is registered.
// The walk reads the run slot memory one slot per cycle.
// The output register holds a result while the next request is taken in.
// Reset (rst_n low, synchronous) empties the queue and run slots, clears the
// counters and loads queue_capacity 16 and core_count 32.
`timescale 1ns / 1ps

module multicore_job_dispatcher_top (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  mjd_pkg::job_in_t        in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output mjd_pkg::result_t        out_data,
  input  logic                    cfg_we,
  input  logic [mjd_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [mjd_pkg::CFG_DW-1:0] cfg_wdata
);
  import mjd_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ARR  = 3'd1;
  localparam logic [2:0] S_HEAD = 3'd2;
  localparam logic [2:0] S_DISP = 3'd3;
  localparam logic [2:0] S_SCAN = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  function automatic logic [STAT_W-1:0] sat_inc(input logic [STAT_W-1:0] v);
    sat_inc = (v == STAT_MAX) ? v : STAT_W'(v + 1'b1);
  endfunction

  // Storage
  job_entry_t           q_mem [QUEUE_DEPTH];
  logic [TICK_BITS-1:0] slot_ticks_mem [MAX_CORES];
  logic [CORE_W-1:0]    slot_cores_mem [MAX_CORES];

  logic [2:0]           state_r, state_nxt;
  job_in_t              in_r, in_nxt;
  logic [QCAP_W-1:0]    qcap_r;
  logic [CORE_W-1:0]    core_cfg_r;
  logic [QW-1:0]        q_head_r, q_head_nxt;
  logic [QCNT_W-1:0]    q_count_r, q_count_nxt;
  logic [MAX_CORES-1:0] slot_valid_r, slot_valid_nxt;
  logic [CORE_W-1:0]    busy_r, busy_nxt;
  logic [STAT_W-1:0]    gen_r, gen_nxt, compl_r, compl_nxt, full_r, full_nxt;
  logic [STAT_W-1:0]    wide_r, wide_nxt, idle_cnt_r, idle_cnt_nxt;
  logic [1:0]           status_r, status_nxt;
  logic                 disp_r, disp_nxt;
  logic                 pend_r, pend_nxt;
  logic                 idle_r, idle_nxt;
  logic [5:0]           done_r, done_nxt;
  logic [SW:0]          scan_idx_r, scan_idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  result_t              out_data_r, out_data_nxt;
  job_entry_t           q_rd_r;
  logic [TICK_BITS-1:0] s_rd_ticks_r;
  logic [CORE_W-1:0]    s_rd_cores_r;

  // Memory controls
  logic                 q_we;
  logic [QW-1:0]        q_waddr;
  logic                 s_we;
  logic [SW-1:0]        s_waddr;
  logic [TICK_BITS-1:0] s_wticks;
  logic [CORE_W-1:0]    s_wcores;

  // Working values
  logic [QCNT_W-1:0]    eff_cap;
  logic [CORE_W-1:0]    ncores;
  logic [QW:0]          tail_sum;
  logic [QW-1:0]        tail;
  logic [SW:0]          proc_idx;
  logic [SW-1:0]        pj;
  logic                 is_disp;
  logic                 v_eff;
  logic [TICK_BITS-1:0] t_eff;
  logic [CORE_W-1:0]    c_eff;

  assign eff_cap = (32'(qcap_r) > 32'(QUEUE_DEPTH)) ? QCNT_W'(QUEUE_DEPTH)
                                                     : QCNT_W'(qcap_r);
  assign ncores  = (32'(core_cfg_r) > 32'(MAX_CORES)) ? CORE_W'(MAX_CORES) : core_cfg_r;

  assign tail_sum = (QW+1)'(q_head_r) + (QW+1)'(q_count_r);
  assign tail     = (32'(tail_sum) >= 32'(QUEUE_DEPTH))
                    ? QW'(tail_sum - (QW+1)'(QUEUE_DEPTH)) : tail_sum[QW-1:0];

  assign proc_idx = scan_idx_r - 1'b1;
  assign pj       = proc_idx[SW-1:0];
  // The job dispatched this tick takes the first free slot that the walk meets.
  assign is_disp  = pend_r && !slot_valid_r[pj];
  assign v_eff    = slot_valid_r[pj] || is_disp;
  assign t_eff    = is_disp ? q_rd_r.ticks : s_rd_ticks_r;
  assign c_eff    = is_disp ? q_rd_r.cores : s_rd_cores_r;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt      = state_r;
    in_nxt         = in_r;
    q_head_nxt     = q_head_r;
    q_count_nxt    = q_count_r;
    slot_valid_nxt = slot_valid_r;
    busy_nxt       = busy_r;
    gen_nxt        = gen_r;
    compl_nxt      = compl_r;
    full_nxt       = full_r;
    wide_nxt       = wide_r;
    idle_cnt_nxt   = idle_cnt_r;
    status_nxt     = status_r;
    disp_nxt       = disp_r;
    pend_nxt       = pend_r;
    idle_nxt       = idle_r;
    done_nxt       = done_r;
    scan_idx_nxt   = scan_idx_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    q_we           = 1'b0;
    q_waddr        = tail;
    s_we           = 1'b0;
    s_waddr        = pj;
    s_wticks       = TICK_BITS'(t_eff - 1'b1);
    s_wcores       = c_eff;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          in_nxt    = in_data;
          state_nxt = S_ARR;
        end
      end
      S_ARR: begin
        status_nxt = ARR_NONE;
        done_nxt   = '0;
        if (in_r.job_arrives) begin
          if (q_count_r >= eff_cap) begin
            status_nxt = ARR_FULL;
            full_nxt   = sat_inc(full_r);
          end else begin
            gen_nxt = sat_inc(gen_r);
            if (in_r.job_cores > ncores) begin
              status_nxt = ARR_WIDE;
              wide_nxt   = sat_inc(wide_r);
            end else begin
              q_we        = 1'b1;
              q_count_nxt = QCNT_W'(q_count_r + 1'b1);
              status_nxt  = ARR_QUEUED;
            end
          end
        end
        state_nxt = S_HEAD;
      end
      S_HEAD: begin
        state_nxt = S_DISP;
      end
      S_DISP: begin
        idle_nxt = (q_count_r == '0) && !(|slot_valid_r);
        if (idle_nxt) begin
          idle_cnt_nxt = sat_inc(idle_cnt_r);
        end
        disp_nxt = 1'b0;
        pend_nxt = 1'b0;
        if ((q_count_r != '0) && (busy_r <= ncores) &&
            (q_rd_r.cores <= CORE_W'(ncores - busy_r)) && !(&slot_valid_r)) begin
          disp_nxt    = 1'b1;
          pend_nxt    = 1'b1;
          busy_nxt    = CORE_W'(busy_r + q_rd_r.cores);
          q_count_nxt = QCNT_W'(q_count_r - 1'b1);
          q_head_nxt  = (32'(q_head_r) == QUEUE_DEPTH - 1) ? '0 : QW'(q_head_r + 1'b1);
        end
        scan_idx_nxt = '0;
        state_nxt    = S_SCAN;
      end
      S_SCAN: begin
        // Slot memory data for slot scan_idx_r-1 arrived this cycle.
        if (scan_idx_r != '0) begin
          if (is_disp) begin
            pend_nxt = 1'b0;
          end
          if (v_eff) begin
            if (t_eff <= TICK_BITS'(1)) begin
              slot_valid_nxt[pj] = 1'b0;
              busy_nxt           = (busy_r >= c_eff) ? CORE_W'(busy_r - c_eff) : '0;
              done_nxt           = 6'(done_r + 1'b1);
              compl_nxt          = sat_inc(compl_r);
            end else begin
              slot_valid_nxt[pj] = 1'b1;
              s_we               = 1'b1;
            end
          end
        end
        if (32'(scan_idx_r) == MAX_CORES) begin
          state_nxt = S_DONE;
        end else begin
          scan_idx_nxt = (SW+1)'(scan_idx_r + 1'b1);
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.arrival_status  = status_r;
          out_data_nxt.dispatched      = disp_r;
          out_data_nxt.completed_now   = done_r;
          out_data_nxt.idle_tick       = idle_r;
          out_data_nxt.free_cores      = (busy_r < ncores) ? CORE_W'(ncores - busy_r) : '0;
          out_data_nxt.queue_fill      = 5'(q_count_r);
          out_data_nxt.tasks_generated = gen_r;
          out_data_nxt.total_completed = compl_r;
          out_data_nxt.total_queue_full = full_r;
          out_data_nxt.total_too_wide  = wide_r;
          out_data_nxt.total_idle      = idle_cnt_r;
          state_nxt                    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      qcap_r       <= QCAP_RESET;
      core_cfg_r   <= CORES_RESET;
      q_head_r     <= '0;
      q_count_r    <= '0;
      slot_valid_r <= '0;
      busy_r       <= '0;
      gen_r        <= '0;
      compl_r      <= '0;
      full_r       <= '0;
      wide_r       <= '0;
      idle_cnt_r   <= '0;
      pend_r       <= 1'b0;
      scan_idx_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      q_head_r     <= q_head_nxt;
      q_count_r    <= q_count_nxt;
      slot_valid_r <= slot_valid_nxt;
      busy_r       <= busy_nxt;
      gen_r        <= gen_nxt;
      compl_r      <= compl_nxt;
      full_r       <= full_nxt;
      wide_r       <= wide_nxt;
      idle_cnt_r   <= idle_cnt_nxt;
      pend_r       <= pend_nxt;
      scan_idx_r   <= scan_idx_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          REG_QUEUE_CAPACITY: qcap_r     <= cfg_wdata[QCAP_W-1:0];
          REG_CORE_COUNT:     core_cfg_r <= cfg_wdata[CORE_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    in_r       <= in_nxt;
    status_r   <= status_nxt;
    disp_r     <= disp_nxt;
    idle_r     <= idle_nxt;
    done_r     <= done_nxt;
    out_data_r <= out_data_nxt;
  end

  // Wait queue: written at the tail, head read registered.
  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[q_waddr] <= '{cores: in_r.job_cores, ticks: in_r.job_ticks};
    end
    if (state_r == S_HEAD) begin
      q_rd_r <= q_mem[q_head_r];
    end
  end

  // Run slot memory: one write and one registered read per cycle of the walk.
  always_ff @(posedge clk) begin
    if (s_we) begin
      slot_ticks_mem[s_waddr] <= s_wticks;
      slot_cores_mem[s_waddr] <= s_wcores;
    end
    if ((state_r == S_SCAN) && (32'(scan_idx_r) < MAX_CORES)) begin
      s_rd_ticks_r <= slot_ticks_mem[scan_idx_r[SW-1:0]];
      s_rd_cores_r <= slot_cores_mem[scan_idx_r[SW-1:0]];
    end
  end

endmodule

// ----- design/mjd_checker.sv -----
// Port-level assertions for the multicore job dispatcher, bound to the top level.
`timescale 1ns / 1ps

module mjd_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input mjd_pkg::job_in_t           in_data,
  input logic                       out_valid,
  input logic                       out_ready,
  input mjd_pkg::result_t           out_data,
  input logic                       cfg_we,
  input logic [mjd_pkg::CFG_AW-1:0] cfg_addr,
  input logic [mjd_pkg::CFG_DW-1:0] cfg_wdata
);
  import mjd_pkg::*;

  // A stalled result must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // After a request is accepted, in_ready drops.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted on back-to-back cycles");

  // An idle tick has an empty queue and nothing running.
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.idle_tick |->
      !out_data.dispatched && out_data.completed_now == 6'd0 &&
      out_data.queue_fill == 5'd0)
    else $error("idle tick with activity");

  // The queue never holds more than its depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_data.queue_fill) <= QUEUE_DEPTH)
    else $error("queue fill above depth");

  // A completion this tick shows in the cumulative count.
  a_done_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.completed_now != 6'd0 |-> out_data.total_completed != '0)
    else $error("completion not counted");

endmodule

bind multicore_job_dispatcher_top mjd_checker u_mjd_checker (.*);

// ----- tb/tb_multicore_job_dispatcher_top.sv -----
// Self-checking testbench for the multicore job dispatcher with its own tick-level predictor.
`timescale 1ns / 1ps

module tb_multicore_job_dispatcher_top;
  import mjd_pkg::*;

  typedef enum int {MIX_GENERAL, MIX_ZERO_CORE} job_mix_t;

  class dispatch_scoreboard;
    job_entry_t        waiting [QUEUE_DEPTH];
    int unsigned       head_idx;
    int unsigned       fill;
    bit                slot_busy [MAX_CORES];
    int unsigned       slot_ticks [MAX_CORES];
    int unsigned       slot_cores [MAX_CORES];
    int unsigned       cores_in_use;
    logic [STAT_W-1:0] n_generated, n_completed, n_dropped, n_too_wide, n_idle;
    logic [QCAP_W-1:0] capacity;
    logic [CORE_W-1:0] core_count;
    result_t           expected_q [$];
    int                errors;

    function new();
      head_idx = 0;
      fill = 0;
      cores_in_use = 0;
      errors = 0;
      foreach (slot_busy[i]) slot_busy[i] = 1'b0;
      n_generated = '0;
      n_completed = '0;
      n_dropped = '0;
      n_too_wide = '0;
      n_idle = '0;
      capacity = QCAP_RESET;
      core_count = CORES_RESET;
    endfunction

    static function logic [STAT_W-1:0] sat_inc(logic [STAT_W-1:0] v);
      return (v == STAT_MAX) ? v : v + 1'b1;
    endfunction

    function int unsigned core_limit();
      return (core_count > MAX_CORES) ? MAX_CORES : core_count;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void write_reg(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] data);
      if (addr == REG_QUEUE_CAPACITY) begin
        capacity = data[QCAP_W-1:0];
      end else begin
        core_count = data[CORE_W-1:0];
      end
    endfunction

    // One request is one scheduler tick: arrival, idle check, dispatch, countdown.
    function void note_request(job_in_t req);
      result_t     res;
      int unsigned ncores, cap, done;
      bit          running, placed;
      ncores = core_limit();
      cap = (capacity > QUEUE_DEPTH) ? QUEUE_DEPTH : capacity;
      res = '0;
      done = 0;
      running = 1'b0;
      placed = 1'b0;
      if (req.job_arrives) begin
        // The full check wins over the width check.
        if (fill >= cap) begin
          res.arrival_status = ARR_FULL;
          n_dropped = sat_inc(n_dropped);
        end else begin
          n_generated = sat_inc(n_generated);
          if (req.job_cores > ncores) begin
            res.arrival_status = ARR_WIDE;
            n_too_wide = sat_inc(n_too_wide);
          end else begin
            waiting[(head_idx + fill) % QUEUE_DEPTH] = {req.job_cores, req.job_ticks};
            fill++;
            res.arrival_status = ARR_QUEUED;
          end
        end
      end
      foreach (slot_busy[i]) running |= slot_busy[i];
      if (fill == 0 && !running) begin
        res.idle_tick = 1'b1;
        n_idle = sat_inc(n_idle);
      end
      // Only the oldest waiting job may start, and it also needs a free run slot.
      if (fill != 0 && cores_in_use <= ncores &&
          waiting[head_idx].cores <= ncores - cores_in_use) begin
        for (int i = 0; i < MAX_CORES; i++) begin
          if (!placed && !slot_busy[i]) begin
            slot_busy[i] = 1'b1;
            slot_cores[i] = waiting[head_idx].cores;
            slot_ticks[i] = waiting[head_idx].ticks;
            cores_in_use += waiting[head_idx].cores;
            placed = 1'b1;
          end
        end
        if (placed) begin
          head_idx = (head_idx + 1) % QUEUE_DEPTH;
          fill--;
          res.dispatched = 1'b1;
        end
      end
      for (int i = 0; i < MAX_CORES; i++) begin
        if (slot_busy[i]) begin
          if (slot_ticks[i] <= 1) begin
            slot_busy[i] = 1'b0;
            cores_in_use = (cores_in_use >= slot_cores[i]) ? cores_in_use - slot_cores[i] : 0;
            done++;
            n_completed = sat_inc(n_completed);
          end else begin
            slot_ticks[i]--;
          end
        end
      end
      res.completed_now = done[5:0];
      res.free_cores = (cores_in_use < ncores) ? CORE_W'(ncores - cores_in_use) : '0;
      res.queue_fill = fill[4:0];
      res.tasks_generated = n_generated;
      res.total_completed = n_completed;
      res.total_queue_full = n_dropped;
      res.total_too_wide = n_too_wide;
      res.total_idle = n_idle;
      expected_q.push_back(res);
    endfunction

    function void compare_field(string field, logic [STAT_W-1:0] want, logic [STAT_W-1:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= 100) $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 100) $display("%0t: result expected none, got %h", $time, got);
      end else begin
        want = expected_q.pop_front();
        compare_field("arrival_status", want.arrival_status, got.arrival_status);
        compare_field("dispatched", want.dispatched, got.dispatched);
        compare_field("completed_now", want.completed_now, got.completed_now);
        compare_field("idle_tick", want.idle_tick, got.idle_tick);
        compare_field("free_cores", want.free_cores, got.free_cores);
        compare_field("queue_fill", want.queue_fill, got.queue_fill);
        compare_field("tasks_generated", want.tasks_generated, got.tasks_generated);
        compare_field("total_completed", want.total_completed, got.total_completed);
        compare_field("total_queue_full", want.total_queue_full, got.total_queue_full);
        compare_field("total_too_wide", want.total_too_wide, got.total_too_wide);
        compare_field("total_idle", want.total_idle, got.total_idle);
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  job_in_t           in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  result_t           out_data;
  logic              cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;
  bit                gaps_on = 1'b1;
  int                ready_hold = 0;
  dispatch_scoreboard sb;

  multicore_job_dispatcher_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Result side: back-pressure comes in bursts of random length.
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
      out_ready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      ready_hold <= $urandom_range(0, 6);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  function automatic job_in_t job(bit arrives, int unsigned cores, int unsigned ticks);
    job_in_t j;
    j.job_arrives = arrives;
    j.job_cores = cores[CORE_W-1:0];
    j.job_ticks = ticks[TICK_BITS-1:0];
    return j;
  endfunction

  function automatic job_in_t make_job(job_mix_t mix, int unsigned ncores);
    int unsigned c, t;
    bit          arrives;
    arrives = ($urandom_range(0, 9) < 8);
    if (mix == MIX_ZERO_CORE) begin
      // Long zero-core jobs pile up in the run slots until none is left.
      arrives = 1'b1;
      c = 0;
      t = $urandom_range(40, 70);
    end else begin
      case ($urandom_range(0, 9))
        0:       c = 0;
        1:       c = $urandom_range(0, 63);
        2, 3:    c = (ncores == 0) ? 0 : $urandom_range(1, ncores);
        default: c = $urandom_range(1, (ncores > 7) ? ncores / 4 : 2);
      endcase
      // Rejected jobs never run, so they can carry any duration.
      if (c > ncores) begin
        t = $urandom_range(0, 65535);
      end else begin
        case ($urandom_range(0, 15))
          0:       t = 0;
          1, 2:    t = $urandom_range(13, 60);
          default: t = $urandom_range(1, 12);
        endcase
      end
    end
    return job(arrives, c, t);
  endfunction

  task automatic send_request(input job_in_t j);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= j;
    do @(posedge clk); while (!(in_valid && in_ready));
    sb.note_request(j);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic set_config(input int unsigned cap, input int unsigned ncores);
    cfg_we <= 1'b1;
    cfg_addr <= REG_QUEUE_CAPACITY;
    cfg_wdata <= CFG_DW'(cap);
    @(posedge clk);
    cfg_addr <= REG_CORE_COUNT;
    cfg_wdata <= CFG_DW'(ncores);
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(REG_QUEUE_CAPACITY, CFG_DW'(cap));
    sb.write_reg(REG_CORE_COUNT, CFG_DW'(ncores));
  endtask

  task automatic run_phase(input int unsigned cap, input int unsigned ncores, input int n,
                           input job_mix_t mix);
    set_config(cap, ncores);
    repeat (n) send_request(make_job(mix, sb.core_limit()));
    drain_results();
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset configuration.
    send_request(job(1'b0, 63, 16'hFFFF));
    send_request(job(1'b1, 32, 1));
    send_request(job(1'b1, 33, 16'hFFFF));
    send_request(job(1'b1, 63, 0));
    send_request(job(1'b1, 0, 3));
    send_request(job(1'b1, 5, 0));
    // Full-width jobs block the head long enough for the queue to fill.
    repeat (19) send_request(job(1'b1, 32, 8));
    send_request(job(1'b1, 63, 9));
    drain_results();

    // The queue is still nearly full: shrink the capacity below the fill,
    // then the core count below the cores in use.
    run_phase(2, 32, 40, MIX_GENERAL);
    run_phase(16, 4, 40, MIX_GENERAL);
    run_phase(16, 63, 40, MIX_GENERAL);
    run_phase(31, 32, 40, MIX_GENERAL);
    run_phase(1, 1, 80, MIX_GENERAL);
    run_phase(0, 32, 30, MIX_GENERAL);
    run_phase(16, 0, 40, MIX_GENERAL);
    run_phase(16, 32, 45, MIX_ZERO_CORE);

    for (int k = 0; k < 10; k++) begin
      gaps_on = (k != 4);
      run_phase($urandom_range(1, 16),
                ($urandom_range(0, 3) == 0) ? $urandom_range(1, 32) : $urandom_range(12, 32),
                150, MIX_GENERAL);
    end

    gaps_on = 1'b0;
    run_phase(16, 32, 100, MIX_GENERAL);

    repeat (MAX_CORES + 10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_multicore_job_dispatcher_top OK");
    end else begin
      $display("tb_multicore_job_dispatcher_top NOT OK");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb_multicore_job_dispatcher_top NOT OK");
    $finish;
  end

endmodule
